@@ rtl/core/ptd_pkg.sv @@
// Shared types and constants for the periodic task dispatch table.
// Used by the channel interfaces, the engine, the top level and the checker.
`default_nettype none

package ptd_pkg;

    localparam int PTD_MAX_TASKS = 8;
    localparam int OP_W          = 3;
    localparam int ID_W          = 3;
    localparam int TIME_W        = 32;
    localparam int STATUS_W      = 2;
    localparam int COUNT_W       = 4;

    typedef enum logic [OP_W-1:0] {
        OP_ADD     = 3'd0,
        OP_REMOVE  = 3'd1,
        OP_SET_IVL = 3'd2,
        OP_ENABLE  = 3'd3,
        OP_DISABLE = 3'd4,
        OP_RUN     = 3'd5,
        OP_CLEAR   = 3'd6
    } ptd_op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_BAD  = 2'd1,
        ST_FULL = 2'd2
    } ptd_status_t;

    typedef struct packed {
        logic              en;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] last_run;
    } ptd_entry_t;

    localparam int ENTRY_W = $bits(ptd_entry_t);

endpackage

`default_nettype wire

@@ rtl/core/ptd_in_if.sv @@
// Request channel: one operation transaction per handshake.
// Depends on ptd_pkg for field widths.
`default_nettype none

interface ptd_in_if;
    import ptd_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [ID_W-1:0]     task_id;
    logic [TIME_W-1:0]   period_ms;
    logic [TIME_W-1:0]   now_ms;

    modport source (
        output valid, operation, task_id, period_ms, now_ms,
        input  ready
    );

    modport sink (
        input  valid, operation, task_id, period_ms, now_ms,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/core/ptd_out_if.sv @@
// Result channel: one result transaction per handshake.
// Depends on ptd_pkg for field widths.
`default_nettype none

interface ptd_out_if;
    import ptd_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                fired;
    logic [ID_W-1:0]     fired_task;
    logic                last;
    logic [COUNT_W-1:0]  task_count;

    modport source (
        output valid, status, fired, fired_task, last, task_count,
        input  ready
    );

    modport sink (
        input  valid, status, fired, fired_task, last, task_count,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/core/ptd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ptd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/core/ptd_engine.sv @@
// Operation sequencer: decodes requests, walks the task table RAM and drives
// the registered result stage. Depends on ptd_pkg, ptd_in_if and ptd_out_if.
`default_nettype none

module ptd_engine #(
    parameter int MAX_TASKS = ptd_pkg::PTD_MAX_TASKS,
    parameter int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    ptd_in_if.sink                  req,
    ptd_out_if.source               rsp,
    output logic                    ram_we,
    output logic [IDX_W-1:0]        ram_waddr,
    output ptd_pkg::ptd_entry_t     ram_wdata,
    output logic [IDX_W-1:0]        ram_raddr,
    input  wire ptd_pkg::ptd_entry_t ram_rdata
);
    import ptd_pkg::*;

    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int XW    = ((CNT_W > ID_W) ? CNT_W : ID_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_MODIFY,
        S_SHIFT,
        S_SCAN,
        S_FINISH,
        S_FLUSH
    } state_t;

    state_t              state_reg,      state_next;
    logic [CNT_W-1:0]    cnt_reg,        cnt_next;
    logic [OP_W-1:0]     op_reg,         op_next;
    logic [ID_W-1:0]     id_reg,         id_next;
    logic [TIME_W-1:0]   ivl_reg,        ivl_next;
    logic [TIME_W-1:0]   now_reg,        now_next;
    logic [IDX_W-1:0]    idx_reg,        idx_next;
    ptd_status_t         status_reg,     status_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]    pend_idx_reg,   pend_idx_next;
    logic                out_valid_reg,  out_valid_next;
    ptd_status_t         out_status_reg, out_status_next;
    logic                out_fired_reg,  out_fired_next;
    logic [ID_W-1:0]     out_task_reg,   out_task_next;
    logic                out_last_reg,   out_last_next;
    logic [COUNT_W-1:0]  out_count_reg,  out_count_next;

    logic                out_free;
    logic                id_ok;
    logic [XW-1:0]       id_x;
    logic [XW-1:0]       cnt_x;
    logic [XW-1:0]       idx_x;
    logic [CNT_W-1:0]    cnt_after;
    logic [TIME_W-1:0]   elapsed;
    logic                due;
    ptd_entry_t          entry;
    logic                emit;
    ptd_status_t         e_status;
    logic                e_fired;
    logic [IDX_W-1:0]    e_task;
    logic                e_last;

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.fired      = out_fired_reg;
    assign rsp.fired_task = out_task_reg;
    assign rsp.last       = out_last_reg;
    assign rsp.task_count = out_count_reg;

    assign out_free = !out_valid_reg || rsp.ready;
    assign id_x     = XW'(id_reg);
    assign cnt_x    = XW'(cnt_reg);
    assign idx_x    = XW'(idx_reg);
    assign id_ok    = (id_x < cnt_x);
    assign entry    = ram_rdata;
    assign elapsed  = now_reg - entry.last_run;
    assign due      = entry.en && (elapsed >= entry.period);

    always_comb
    begin
        cnt_after = cnt_reg;
        unique case (ptd_op_t'(op_reg))
            OP_ADD:
            begin
                if (status_reg == ST_OK)
                begin
                    cnt_after = CNT_W'(cnt_x + XW'(1));
                end
            end
            OP_REMOVE:
            begin
                if (status_reg == ST_OK)
                begin
                    cnt_after = CNT_W'(cnt_x - XW'(1));
                end
            end
            OP_CLEAR:
            begin
                cnt_after = '0;
            end
            default:
            begin
                cnt_after = cnt_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        ivl_next        = ivl_reg;
        now_next        = now_reg;
        idx_next        = idx_reg;
        status_next     = status_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = entry;
        ram_raddr       = idx_reg;
        emit            = 1'b0;
        e_status        = status_reg;
        e_fired         = 1'b0;
        e_task          = '0;
        e_last          = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.operation;
                    id_next    = req.task_id;
                    ivl_next   = req.period_ms;
                    now_next   = req.now_ms;
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                status_next = ST_OK;
                state_next  = S_FINISH;
                unique case (ptd_op_t'(op_reg))
                    OP_ADD:
                    begin
                        if (ivl_reg == '0)
                        begin
                            status_next = ST_BAD;
                        end
                        else if (cnt_x >= XW'(MAX_TASKS))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            ram_we             = 1'b1;
                            ram_waddr          = IDX_W'(cnt_reg);
                            ram_wdata.en       = 1'b1;
                            ram_wdata.period   = ivl_reg;
                            ram_wdata.last_run = now_reg;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (!id_ok)
                        begin
                            status_next = ST_BAD;
                        end
                        else if ((id_x + XW'(1)) < cnt_x)
                        begin
                            idx_next   = IDX_W'(id_reg);
                            ram_raddr  = IDX_W'(id_x + XW'(1));
                            state_next = S_SHIFT;
                        end
                    end
                    OP_SET_IVL, OP_ENABLE, OP_DISABLE:
                    begin
                        if (!id_ok)
                        begin
                            status_next = ST_BAD;
                        end
                        else
                        begin
                            ram_raddr  = IDX_W'(id_reg);
                            state_next = S_MODIFY;
                        end
                    end
                    OP_RUN:
                    begin
                        pend_valid_next = 1'b0;
                        if (cnt_reg == '0)
                        begin
                            state_next = S_FLUSH;
                        end
                        else
                        begin
                            idx_next   = '0;
                            ram_raddr  = '0;
                            state_next = S_SCAN;
                        end
                    end
                    OP_CLEAR:
                    begin
                        status_next = ST_OK;
                    end
                    default:
                    begin
                        status_next = ST_BAD;
                    end
                endcase
            end

            S_MODIFY:
            begin
                ram_we    = 1'b1;
                ram_waddr = IDX_W'(id_reg);
                unique case (ptd_op_t'(op_reg))
                    OP_SET_IVL:
                    begin
                        ram_wdata.period = ivl_reg;
                    end
                    OP_ENABLE:
                    begin
                        ram_wdata.en       = 1'b1;
                        ram_wdata.last_run = now_reg;
                    end
                    default:
                    begin
                        ram_wdata.en = 1'b0;
                    end
                endcase
                state_next = S_FINISH;
            end

            S_SHIFT:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                if ((idx_x + XW'(2)) < cnt_x)
                begin
                    idx_next  = IDX_W'(idx_x + XW'(1));
                    ram_raddr = IDX_W'(idx_x + XW'(2));
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            S_SCAN:
            begin
                if (!(due && pend_valid_reg && !out_free))
                begin
                    if (due)
                    begin
                        ram_we             = 1'b1;
                        ram_waddr          = idx_reg;
                        ram_wdata.last_run = now_reg;
                        emit               = pend_valid_reg;
                        e_status           = ST_OK;
                        e_fired            = 1'b1;
                        e_task             = pend_idx_reg;
                        e_last             = 1'b0;
                        pend_valid_next    = 1'b1;
                        pend_idx_next      = idx_reg;
                    end
                    if ((idx_x + XW'(1)) < cnt_x)
                    begin
                        idx_next  = IDX_W'(idx_x + XW'(1));
                        ram_raddr = IDX_W'(idx_x + XW'(1));
                    end
                    else
                    begin
                        state_next = S_FLUSH;
                    end
                end
            end

            S_FINISH:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    cnt_next   = cnt_after;
                    state_next = S_IDLE;
                end
            end

            S_FLUSH:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    e_status   = ST_OK;
                    e_fired    = pend_valid_reg;
                    e_task     = pend_valid_reg ? pend_idx_reg : '0;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_fired_next  = out_fired_reg;
        out_task_next   = out_task_reg;
        out_last_next   = out_last_reg;
        out_count_next  = out_count_reg;
        if (emit)
        begin
            out_valid_next  = 1'b1;
            out_status_next = e_status;
            out_fired_next  = e_fired;
            out_task_next   = ID_W'(e_task);
            out_last_next   = e_last;
            out_count_next  = COUNT_W'(cnt_after);
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            op_reg         <= '0;
            id_reg         <= '0;
            ivl_reg        <= '0;
            now_reg        <= '0;
            idx_reg        <= '0;
            status_reg     <= ST_OK;
            pend_valid_reg <= 1'b0;
            pend_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_OK;
            out_fired_reg  <= 1'b0;
            out_task_reg   <= '0;
            out_last_reg   <= 1'b0;
            out_count_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            op_reg         <= op_next;
            id_reg         <= id_next;
            ivl_reg        <= ivl_next;
            now_reg        <= now_next;
            idx_reg        <= idx_next;
            status_reg     <= status_next;
            pend_valid_reg <= pend_valid_next;
            pend_idx_reg   <= pend_idx_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_fired_reg  <= out_fired_next;
            out_task_reg   <= out_task_next;
            out_last_reg   <= out_last_next;
            out_count_reg  <= out_count_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/periodic_task_dispatch_table_core.sv @@
// Periodic task dispatch table (interval timer task scheduler).
// Channels: req carries one operation per transaction (add, remove, set
// interval, enable, disable, run, clear) with task_id, period_ms, now_ms.
// rsp carries result transactions: status, fired, fired_task, last and the
// task count after the operation. Every operation gives one result with
// last set, except run, which gives one result per due task (last on the
// final one) or a single non-fired result when nothing is due.
// Add, clear and rejected operations go from dispatch straight to the
// finish state; set interval, enable and disable pass a modify state
// first; remove moves each later entry down one place; run reads every
// table entry in turn. The engine walks the single read port of the task
// table RAM one entry a cycle, except while a due task waits on rsp.
// One request is in flight at a time; req.ready is high while idle, also
// while the last result still waits in the output register.
// Reset empties the table (count zero) and clears the output register.
// When rsp stalls, the engine holds its scan at a due task until the
// output register frees, and no result is dropped. Depends on ptd_pkg,
// ptd_in_if, ptd_out_if, ptd_ram and ptd_engine.
`default_nettype none

module periodic_task_dispatch_table_core #(
    parameter int MAX_TASKS = ptd_pkg::PTD_MAX_TASKS
) (
    input  wire logic clk,
    input  wire logic rst_n,
    ptd_in_if.sink    req,
    ptd_out_if.source rsp
);
    import ptd_pkg::*;

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    ptd_entry_t          ram_wdata;
    logic [IDX_W-1:0]    ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;

    ptd_engine #(
        .MAX_TASKS (MAX_TASKS),
        .IDX_W     (IDX_W)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ptd_entry_t'(ram_rdata))
    );

    ptd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TASKS),
        .AW    (IDX_W)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ENTRY_W'(ram_wdata)),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

@@ rtl/core/ptd_chk.sv @@
// Port-level checker for the dispatch table core, attached by bind.
// Depends on ptd_pkg and periodic_task_dispatch_table_core.
`default_nettype none

module ptd_chk (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         rsp_valid,
    input wire logic                         rsp_ready,
    input wire logic [ptd_pkg::STATUS_W-1:0] rsp_status,
    input wire logic                         rsp_fired,
    input wire logic [ptd_pkg::ID_W-1:0]     rsp_fired_task,
    input wire logic                         rsp_last,
    input wire logic [ptd_pkg::COUNT_W-1:0]  rsp_task_count
);
    import ptd_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_fired) && $stable(rsp_fired_task)
            && $stable(rsp_last) && $stable(rsp_task_count))
        else $error("result changed while stalled");

    a_nonfired_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_fired |-> rsp_last)
        else $error("non-fired result not marked last");

    a_fired_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_fired |-> rsp_status == ST_OK)
        else $error("fired result with error status");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_status == ST_OK || rsp_status == ST_BAD
            || rsp_status == ST_FULL)
        else $error("undefined status code");

endmodule

bind periodic_task_dispatch_table_core ptd_chk u_ptd_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.status),
    .rsp_fired      (rsp.fired),
    .rsp_fired_task (rsp.fired_task),
    .rsp_last       (rsp.last),
    .rsp_task_count (rsp.task_count)
);

`default_nettype wire
